### src/apvd_pkg.sv
package apvd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int INDEX_BITS     = 16;
  localparam int MAX_LENGTH     = 65536;
  localparam int INDEX_TOP_INT  = (MAX_LENGTH - 1 < (1 << INDEX_BITS) - 1) ?
                                  MAX_LENGTH - 1 : (1 << INDEX_BITS) - 1;
  localparam logic [INDEX_BITS-1:0] INDEX_TOP = INDEX_TOP_INT[INDEX_BITS-1:0];
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic KIND_MAX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]         index;
  } result_t;

  typedef struct packed {
    logic    rev_vld;
    logic    fin_vld;
    result_t rev;
    result_t fin;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### src/apvd_front.sv
module apvd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [apvd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  apvd_pkg::queue_stat_t                  qs,
  output logic                                   push,
  output apvd_pkg::entry_t                       entry
);
  import apvd_pkg::*;

  phase_t                        phase, phase_next;
  logic signed [SAMPLE_BITS-1:0] held_value, held_value_next;
  logic [INDEX_BITS-1:0]         held_index, held_index_next;
  logic [INDEX_BITS-1:0]         position, position_next;
  logic                          rising, rising_next;
  logic                          accept;
  logic                          rev;
  logic                          hold;
  logic [INDEX_BITS-1:0]         pos_cur;
  logic                          ris_cur;

  assign in_stall = qs.full;
  assign accept   = in_valid && !qs.full;

  always_comb begin
    rev     = 1'b0;
    hold    = 1'b0;
    pos_cur = position;
    ris_cur = rising;
    unique case (phase)
      PH_SECOND: begin
        ris_cur = (sample >= held_value);
        hold    = (sample != held_value);
      end
      PH_RUN: begin
        if (rising) begin
          if (held_value < sample) begin
            hold = 1'b1;
          end else if (held_value > sample) begin
            hold    = 1'b1;
            rev     = 1'b1;
            ris_cur = 1'b0;
          end
        end else begin
          if (held_value > sample) begin
            hold = 1'b1;
          end else if (held_value < sample) begin
            hold    = 1'b1;
            rev     = 1'b1;
            ris_cur = 1'b1;
          end
        end
      end
      default: begin
        pos_cur = '0;
        ris_cur = 1'b1;
        hold    = 1'b1;
      end
    endcase

    held_value_next = hold ? sample  : held_value;
    held_index_next = hold ? pos_cur : held_index;

    entry.rev_vld   = rev;
    entry.fin_vld   = last;
    entry.rev.kind  = rising ? KIND_MAX : KIND_MIN;
    entry.rev.value = held_value;
    entry.rev.index = held_index;
    entry.fin.kind  = ris_cur ? KIND_MAX : KIND_MIN;
    entry.fin.value = held_value_next;
    entry.fin.index = held_index_next;

    push = accept && (rev || last);

    if (last) begin
      phase_next      = PH_FIRST;
      rising_next     = 1'b1;
      position_next   = '0;
      held_value_next = '0;
      held_index_next = '0;
    end else begin
      phase_next    = (phase == PH_FIRST) ? PH_SECOND : PH_RUN;
      rising_next   = ris_cur;
      position_next = (pos_cur < INDEX_TOP) ? pos_cur + 1'b1 : pos_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      rising     <= 1'b1;
      position   <= '0;
      held_value <= '0;
      held_index <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      rising     <= rising_next;
      position   <= position_next;
      held_value <= held_value_next;
      held_index <= held_index_next;
    end
  end

endmodule

### src/apvd_queue.sv
module apvd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  apvd_pkg::entry_t      wr_entry,
  input  logic                  pop,
  output apvd_pkg::entry_t      head,
  output apvd_pkg::queue_stat_t qs
);
  import apvd_pkg::*;

  entry_t                    mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign qs.full  = (count == QUEUE_PTR_BITS'(0) + (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign qs.empty = (count == '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/apvd_back.sv
module apvd_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  apvd_pkg::entry_t                        head,
  input  apvd_pkg::queue_stat_t                   qs,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    kind,
  output logic signed [apvd_pkg::SAMPLE_BITS-1:0] extremum_value,
  output logic [apvd_pkg::INDEX_BITS-1:0]         extremum_index,
  output logic                                    end_of_run
);
  import apvd_pkg::*;

  logic    done;
  logic    show_rev;
  logic    xfer;
  result_t res;

  assign out_valid      = !qs.empty;
  assign show_rev       = head.rev_vld && !done;
  assign res            = show_rev ? head.rev : head.fin;
  assign kind           = res.kind;
  assign extremum_value = res.value;
  assign extremum_index = res.index;
  assign end_of_run     = !show_rev;
  assign xfer           = out_valid && !out_stall;
  assign pop            = xfer && !(show_rev && head.fin_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (xfer) begin
      done <= !pop;
    end
  end

endmodule

### src/alternating_peak_valley_detector_top.sv
// Channel  Handshake             Payload
// input    in_valid / in_stall   sample, last
// output   out_valid / out_stall kind, extremum_value, extremum_index, end_of_run
//
// One sample a cycle while in_stall is low; each sample is classified in the
// cycle it transfers. Results leave one a cycle while out_stall is low, from a
// four-entry queue; a sample with two results gives reversal, then end of run.
// Synchronous reset rst returns to awaiting the first sample of a stream.
// in_stall rises only while the queue is full; out_stall holds the head.
module alternating_peak_valley_detector_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [apvd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    kind,
  output logic signed [apvd_pkg::SAMPLE_BITS-1:0] extremum_value,
  output logic [apvd_pkg::INDEX_BITS-1:0]         extremum_index,
  output logic                                    end_of_run
);
  import apvd_pkg::*;

  entry_t      wr_entry;
  entry_t      head;
  queue_stat_t qs;
  logic        push;
  logic        pop;

  apvd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .last     (last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .qs       (qs),
    .push     (push),
    .entry    (wr_entry)
  );

  apvd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  apvd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .qs             (qs),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .extremum_value (extremum_value),
    .extremum_index (extremum_index),
    .end_of_run     (end_of_run)
  );

`ifndef SYNTHESIS
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue flagged full and empty together");

  a_full_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(qs.full) |-> $past(push))
    else $error("queue filled without a push");

  a_fin_follows_rev: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !end_of_run && head.fin_vld) |=>
      (out_valid && end_of_run))
    else $error("end-of-run result lost after reversal");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qs.full |-> !push)
    else $error("push into a full queue");
`endif

endmodule
